/* hw/rtl/sqvt_pkg.sv */
`timescale 1ns / 1ps
package sqvt_pkg;

  localparam int unsigned SINE_TABLE_ENTRIES_DFLT = 1024;
  localparam int unsigned FRACTION_BITS_DFLT      = 16;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned SCALE_W    = 16;
  localparam int unsigned ANGLE_W    = 13;
  localparam int unsigned EXTENT_W   = 31;
  // scaled local coordinates live in [-2^35, 2^35-1]
  localparam int unsigned LOC_W      = 36;
  localparam int unsigned SCALE_FRAC = 8;
  // wide enough for any value that gets clamped to 32 bits
  localparam int unsigned SAT_W      = 40;

  localparam int unsigned TURN_SIXTEENTHS = 5760;
  localparam logic [ANGLE_W-1:0] TURN = ANGLE_W'(TURN_SIXTEENTHS);
  // angle-to-index reciprocal precision
  localparam int unsigned IDX_SHIFT = 26;

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;
  localparam logic [63:0] Q30_PI      = 64'd3373259426;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

  localparam logic signed [SAT_W-1:0] S32_MAX = SAT_W'(64'sd2147483647);
  localparam logic signed [SAT_W-1:0] S32_MIN = SAT_W'(-64'sd2147483648);

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] size_w;
    logic signed [COORD_W-1:0] size_h;
    logic signed [SCALE_W-1:0] scale_x;
    logic signed [SCALE_W-1:0] scale_y;
    logic        [ANGLE_W-1:0] angle;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
  } sqvt_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  corner1_x;
    logic signed [COORD_W-1:0]  corner1_y;
    logic signed [COORD_W-1:0]  corner2_x;
    logic signed [COORD_W-1:0]  corner2_y;
    logic signed [COORD_W-1:0]  corner3_x;
    logic signed [COORD_W-1:0]  corner3_y;
    logic signed [COORD_W-1:0]  corner4_x;
    logic signed [COORD_W-1:0]  corner4_y;
    logic signed [COORD_W-1:0]  box_min_x;
    logic signed [COORD_W-1:0]  box_min_y;
    logic        [EXTENT_W-1:0] box_width;
    logic        [EXTENT_W-1:0] box_height;
  } sqvt_out_t;

  // clamp to the signed 32-bit range
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [COORD_W-1:0] res;
    if (v > S32_MAX) begin
      res = S32_MAX[COORD_W-1:0];
    end else if (v < S32_MIN) begin
      res = S32_MIN[COORD_W-1:0];
    end else begin
      res = v[COORD_W-1:0];
    end
    return res;
  endfunction

  // sine of a Q30 radian angle in [0, 2*pi), odd series to x^13 on the
  // first-quadrant fold; used only to build constant tables
  function automatic logic signed [31:0] q30_sine(input logic [63:0] ang,
                                                   input int unsigned frac);
    logic [63:0] r;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic        neg;
    r   = ang;
    neg = 1'b0;
    if (r >= Q30_PI) begin
      neg = 1'b1;
      r   = r - Q30_PI;
    end
    if (r > Q30_HALF_PI) begin
      r = Q30_PI - r;
    end
    x2 = (r * r) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s  = (r * t) >> 30;
    s  = (s + (64'd1 << (29 - frac))) >> (30 - frac);
    return neg ? -$signed(s[31:0]) : $signed(s[31:0]);
  endfunction

endpackage

/* hw/rtl/sqvt_sine_rom.sv */
`timescale 1ns / 1ps
module sqvt_sine_rom #(
  parameter int unsigned SINE_TABLE_ENTRIES = sqvt_pkg::SINE_TABLE_ENTRIES_DFLT,
  parameter int unsigned FRACTION_BITS      = sqvt_pkg::FRACTION_BITS_DFLT
) (
  input  logic                                  clk,
  input  logic                                  rd_en,
  input  logic [$clog2(SINE_TABLE_ENTRIES)-1:0] rd_idx,
  output logic signed [FRACTION_BITS+1:0]       sin_val,
  output logic signed [FRACTION_BITS+1:0]       cos_val
);

  localparam int unsigned TRIG_W = FRACTION_BITS + 2;

  logic signed [TRIG_W-1:0] sin_tbl [SINE_TABLE_ENTRIES];
  logic signed [TRIG_W-1:0] cos_tbl [SINE_TABLE_ENTRIES];
  logic signed [TRIG_W-1:0] sin_r;
  logic signed [TRIG_W-1:0] cos_r;

  // constant contents, one entry per table step of a full turn
  for (genvar g = 0; g < SINE_TABLE_ENTRIES; g++) begin : g_entry
    localparam logic [63:0] ANG_S  = (64'(g) * sqvt_pkg::Q30_TWO_PI) /
                                     64'(SINE_TABLE_ENTRIES);
    localparam logic [63:0] ANG_C0 = ANG_S + sqvt_pkg::Q30_HALF_PI;
    localparam logic [63:0] ANG_C  = (ANG_C0 >= sqvt_pkg::Q30_TWO_PI) ?
                                     ANG_C0 - sqvt_pkg::Q30_TWO_PI : ANG_C0;
    assign sin_tbl[g] = TRIG_W'(sqvt_pkg::q30_sine(ANG_S, FRACTION_BITS));
    assign cos_tbl[g] = TRIG_W'(sqvt_pkg::q30_sine(ANG_C, FRACTION_BITS));
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      sin_r <= sin_tbl[rd_idx];
      cos_r <= cos_tbl[rd_idx];
    end
  end

  assign sin_val = sin_r;
  assign cos_val = cos_r;

endmodule

/* hw/rtl/sqvt_front.sv */
`timescale 1ns / 1ps
module sqvt_front #(
  parameter int unsigned SINE_TABLE_ENTRIES = sqvt_pkg::SINE_TABLE_ENTRIES_DFLT,
  parameter int unsigned FRACTION_BITS      = sqvt_pkg::FRACTION_BITS_DFLT
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  sqvt_pkg::sqvt_in_t                     in_data,
  output logic                                   loc_valid,
  input  logic                                   loc_ready,
  output logic signed [sqvt_pkg::LOC_W-1:0]      loc_x,
  output logic signed [sqvt_pkg::LOC_W-1:0]      loc_y,
  output logic signed [sqvt_pkg::LOC_W-1:0]      loc_x2,
  output logic signed [sqvt_pkg::LOC_W-1:0]      loc_y2,
  output logic signed [FRACTION_BITS+1:0]        loc_sin,
  output logic signed [FRACTION_BITS+1:0]        loc_cos,
  output logic                                   loc_zero,
  output logic signed [sqvt_pkg::COORD_W-1:0]    loc_pos_x,
  output logic signed [sqvt_pkg::COORD_W-1:0]    loc_pos_y
);

  localparam int unsigned COORD_W = sqvt_pkg::COORD_W;
  localparam int unsigned SCALE_W = sqvt_pkg::SCALE_W;
  localparam int unsigned ANGLE_W = sqvt_pkg::ANGLE_W;
  localparam int unsigned LOC_W   = sqvt_pkg::LOC_W;
  localparam int unsigned DIFF_W  = COORD_W + 2;
  localparam int unsigned PROD_W  = DIFF_W + SCALE_W;
  localparam int unsigned RSH_W   = PROD_W + 1 - sqvt_pkg::SCALE_FRAC;
  localparam int unsigned IDX_W   = $clog2(SINE_TABLE_ENTRIES);
  // idx = floor(a * ENTRIES / 5760), exact for a < 5760 through this reciprocal
  localparam logic [63:0] ANG_MULT =
    ((64'(SINE_TABLE_ENTRIES) << sqvt_pkg::IDX_SHIFT) +
     64'(sqvt_pkg::TURN_SIXTEENTHS - 1)) / 64'(sqvt_pkg::TURN_SIXTEENTHS);
  localparam int unsigned MULT_W  = $clog2(ANG_MULT + 64'd1);
  localparam int unsigned IPROD_W = ANGLE_W + MULT_W;

  localparam logic signed [PROD_W:0] SC_RND =
    (PROD_W + 1)'(1) << (sqvt_pkg::SCALE_FRAC - 1);
  localparam logic signed [RSH_W-1:0] LOC_MAX = RSH_W'((64'sd1 <<< (LOC_W - 1)) - 64'sd1);
  localparam logic signed [RSH_W-1:0] LOC_MIN = RSH_W'(-(64'sd1 <<< (LOC_W - 1)));

  // round to nearest (ties up) by 1/256, clamp to the local range
  function automatic logic signed [LOC_W-1:0] scale_round(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0]  rnd;
    logic signed [RSH_W-1:0] q;
    logic signed [LOC_W-1:0] res;
    rnd = (PROD_W + 1)'(p) + SC_RND;
    q   = RSH_W'(rnd >>> sqvt_pkg::SCALE_FRAC);
    if (q > LOC_MAX) begin
      res = LOC_MAX[LOC_W-1:0];
    end else if (q < LOC_MIN) begin
      res = LOC_MIN[LOC_W-1:0];
    end else begin
      res = q[LOC_W-1:0];
    end
    return res;
  endfunction

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  assign rdy3     = !v3_r || loc_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // stage 1: local rectangle edges, wrap angle
  logic signed [DIFF_W-1:0]  nx_nxt, nx2_nxt, ny_nxt, ny2_nxt;
  logic        [ANGLE_W-1:0] ang_nxt;
  logic signed [DIFF_W-1:0]  nx_r, nx2_r, ny_r, ny2_r;
  logic signed [SCALE_W-1:0] scx_r, scy_r;
  logic        [ANGLE_W-1:0] ang_r;
  logic signed [COORD_W-1:0] px1_r, py1_r;

  always_comb begin
    nx_nxt  = -DIFF_W'($signed(in_data.origin_x));
    ny_nxt  = -DIFF_W'($signed(in_data.origin_y));
    nx2_nxt = DIFF_W'($signed(in_data.size_w)) - DIFF_W'($signed(in_data.origin_x));
    ny2_nxt = DIFF_W'($signed(in_data.size_h)) - DIFF_W'($signed(in_data.origin_y));
    ang_nxt = (in_data.angle >= sqvt_pkg::TURN) ? in_data.angle - sqvt_pkg::TURN
                                                : in_data.angle;
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      nx_r  <= nx_nxt;
      nx2_r <= nx2_nxt;
      ny_r  <= ny_nxt;
      ny2_r <= ny2_nxt;
      scx_r <= in_data.scale_x;
      scy_r <= in_data.scale_y;
      ang_r <= ang_nxt;
      px1_r <= in_data.pos_x;
      py1_r <= in_data.pos_y;
    end
  end

  // stage 2: scale products, table index
  logic signed [PROD_W-1:0]  sx_nxt, sx2_nxt, sy_nxt, sy2_nxt;
  logic        [IPROD_W-1:0] iprod;
  logic signed [PROD_W-1:0]  sx_r, sx2_r, sy_r, sy2_r;
  logic        [IDX_W-1:0]   idx_r;
  logic                      zero2_r;
  logic signed [COORD_W-1:0] px2_r, py2_r;

  always_comb begin
    sx_nxt  = PROD_W'(nx_r)  * PROD_W'(scx_r);
    sx2_nxt = PROD_W'(nx2_r) * PROD_W'(scx_r);
    sy_nxt  = PROD_W'(ny_r)  * PROD_W'(scy_r);
    sy2_nxt = PROD_W'(ny2_r) * PROD_W'(scy_r);
    iprod   = IPROD_W'(ang_r) * IPROD_W'(ANG_MULT);
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      sx_r    <= sx_nxt;
      sx2_r   <= sx2_nxt;
      sy_r    <= sy_nxt;
      sy2_r   <= sy2_nxt;
      idx_r   <= iprod[sqvt_pkg::IDX_SHIFT +: IDX_W];
      zero2_r <= (ang_r == '0);
      px2_r   <= px1_r;
      py2_r   <= py1_r;
    end
  end

  // stage 3: round and clamp, table read
  logic signed [LOC_W-1:0]   lx_r, lx2_r, ly_r, ly2_r;
  logic                      zero3_r;
  logic signed [COORD_W-1:0] px3_r, py3_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      lx_r    <= scale_round(sx_r);
      lx2_r   <= scale_round(sx2_r);
      ly_r    <= scale_round(sy_r);
      ly2_r   <= scale_round(sy2_r);
      zero3_r <= zero2_r;
      px3_r   <= px2_r;
      py3_r   <= py2_r;
    end
  end

  sqvt_sine_rom #(
    .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES),
    .FRACTION_BITS      (FRACTION_BITS)
  ) u_rom (
    .clk     (clk),
    .rd_en   (rdy3),
    .rd_idx  (idx_r),
    .sin_val (loc_sin),
    .cos_val (loc_cos)
  );

  assign loc_valid = v3_r;
  assign loc_x     = lx_r;
  assign loc_y     = ly_r;
  assign loc_x2    = lx2_r;
  assign loc_y2    = ly2_r;
  assign loc_zero  = zero3_r;
  assign loc_pos_x = px3_r;
  assign loc_pos_y = py3_r;

endmodule

/* hw/rtl/sqvt_rotate.sv */
`timescale 1ns / 1ps
module sqvt_rotate #(
  parameter int unsigned FRACTION_BITS = sqvt_pkg::FRACTION_BITS_DFLT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                loc_valid,
  output logic                                loc_ready,
  input  logic signed [sqvt_pkg::LOC_W-1:0]   loc_x,
  input  logic signed [sqvt_pkg::LOC_W-1:0]   loc_y,
  input  logic signed [sqvt_pkg::LOC_W-1:0]   loc_x2,
  input  logic signed [sqvt_pkg::LOC_W-1:0]   loc_y2,
  input  logic signed [FRACTION_BITS+1:0]     loc_sin,
  input  logic signed [FRACTION_BITS+1:0]     loc_cos,
  input  logic                                loc_zero,
  input  logic signed [sqvt_pkg::COORD_W-1:0] loc_pos_x,
  input  logic signed [sqvt_pkg::COORD_W-1:0] loc_pos_y,
  output logic                                crn_valid,
  input  logic                                crn_ready,
  output logic signed [sqvt_pkg::COORD_W-1:0] crn1_x,
  output logic signed [sqvt_pkg::COORD_W-1:0] crn1_y,
  output logic signed [sqvt_pkg::COORD_W-1:0] crn2_x,
  output logic signed [sqvt_pkg::COORD_W-1:0] crn2_y,
  output logic signed [sqvt_pkg::COORD_W-1:0] crn3_x,
  output logic signed [sqvt_pkg::COORD_W-1:0] crn3_y
);

  localparam int unsigned COORD_W = sqvt_pkg::COORD_W;
  localparam int unsigned LOC_W   = sqvt_pkg::LOC_W;
  localparam int unsigned SAT_W   = sqvt_pkg::SAT_W;
  localparam int unsigned TRIG_W  = FRACTION_BITS + 2;
  localparam int unsigned MUL_W   = LOC_W + TRIG_W;
  localparam int unsigned SUM_W   = MUL_W + 1;
  localparam int unsigned ROT_W   = SUM_W - FRACTION_BITS;
  localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) << (FRACTION_BITS - 1);

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  assign rdy3      = !v3_r || crn_ready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign loc_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= loc_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // stage 1: eight products of local coordinates and sin/cos
  logic signed [MUL_W-1:0]   xc_r, xs_r, yc_r, ys_r, x2c_r, x2s_r, y2c_r, y2s_r;
  logic signed [LOC_W-1:0]   lx1_r, ly1_r, lx21_r, ly21_r;
  logic                      zero1_r;
  logic signed [COORD_W-1:0] px1_r, py1_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      xc_r    <= MUL_W'(loc_x)  * MUL_W'(loc_cos);
      xs_r    <= MUL_W'(loc_x)  * MUL_W'(loc_sin);
      yc_r    <= MUL_W'(loc_y)  * MUL_W'(loc_cos);
      ys_r    <= MUL_W'(loc_y)  * MUL_W'(loc_sin);
      x2c_r   <= MUL_W'(loc_x2) * MUL_W'(loc_cos);
      x2s_r   <= MUL_W'(loc_x2) * MUL_W'(loc_sin);
      y2c_r   <= MUL_W'(loc_y2) * MUL_W'(loc_cos);
      y2s_r   <= MUL_W'(loc_y2) * MUL_W'(loc_sin);
      lx1_r   <= loc_x;
      ly1_r   <= loc_y;
      lx21_r  <= loc_x2;
      ly21_r  <= loc_y2;
      zero1_r <= loc_zero;
      px1_r   <= loc_pos_x;
      py1_r   <= loc_pos_y;
    end
  end

  // stage 2: combine and round, keep the bits above the fraction
  logic signed [SUM_W-1:0]   s1x_nxt, s1y_nxt, s2x_nxt, s2y_nxt, s3x_nxt, s3y_nxt;
  logic signed [ROT_W-1:0]   r1x_r, r1y_r, r2x_r, r2y_r, r3x_r, r3y_r;
  logic signed [LOC_W-1:0]   lx2_r, ly2_r, lx22_r, ly22_r;
  logic                      zero2_r;
  logic signed [COORD_W-1:0] px2_r, py2_r;

  always_comb begin
    s1x_nxt = SUM_W'(xc_r)  - SUM_W'(ys_r)  + RND;
    s1y_nxt = SUM_W'(yc_r)  + SUM_W'(xs_r)  + RND;
    s2x_nxt = SUM_W'(xc_r)  - SUM_W'(y2s_r) + RND;
    s2y_nxt = SUM_W'(y2c_r) + SUM_W'(xs_r)  + RND;
    s3x_nxt = SUM_W'(x2c_r) - SUM_W'(y2s_r) + RND;
    s3y_nxt = SUM_W'(y2c_r) + SUM_W'(x2s_r) + RND;
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      r1x_r   <= s1x_nxt[SUM_W-1:FRACTION_BITS];
      r1y_r   <= s1y_nxt[SUM_W-1:FRACTION_BITS];
      r2x_r   <= s2x_nxt[SUM_W-1:FRACTION_BITS];
      r2y_r   <= s2y_nxt[SUM_W-1:FRACTION_BITS];
      r3x_r   <= s3x_nxt[SUM_W-1:FRACTION_BITS];
      r3y_r   <= s3y_nxt[SUM_W-1:FRACTION_BITS];
      lx2_r   <= lx1_r;
      ly2_r   <= ly1_r;
      lx22_r  <= lx21_r;
      ly22_r  <= ly21_r;
      zero2_r <= zero1_r;
      px2_r   <= px1_r;
      py2_r   <= py1_r;
    end
  end

  // stage 3: bypass rotation for a zero angle, translate, clamp
  logic signed [ROT_W-1:0]   e1x, e1y, e2x, e2y, e3x, e3y;
  logic signed [COORD_W-1:0] c1x_r, c1y_r, c2x_r, c2y_r, c3x_r, c3y_r;

  always_comb begin
    e1x = zero2_r ? ROT_W'(lx2_r)  : r1x_r;
    e1y = zero2_r ? ROT_W'(ly2_r)  : r1y_r;
    e2x = zero2_r ? ROT_W'(lx2_r)  : r2x_r;
    e2y = zero2_r ? ROT_W'(ly22_r) : r2y_r;
    e3x = zero2_r ? ROT_W'(lx22_r) : r3x_r;
    e3y = zero2_r ? ROT_W'(ly22_r) : r3y_r;
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      c1x_r <= sqvt_pkg::sat32(SAT_W'(e1x) + SAT_W'(px2_r));
      c1y_r <= sqvt_pkg::sat32(SAT_W'(e1y) + SAT_W'(py2_r));
      c2x_r <= sqvt_pkg::sat32(SAT_W'(e2x) + SAT_W'(px2_r));
      c2y_r <= sqvt_pkg::sat32(SAT_W'(e2y) + SAT_W'(py2_r));
      c3x_r <= sqvt_pkg::sat32(SAT_W'(e3x) + SAT_W'(px2_r));
      c3y_r <= sqvt_pkg::sat32(SAT_W'(e3y) + SAT_W'(py2_r));
    end
  end

  assign crn_valid = v3_r;
  assign crn1_x    = c1x_r;
  assign crn1_y    = c1y_r;
  assign crn2_x    = c2x_r;
  assign crn2_y    = c2y_r;
  assign crn3_x    = c3x_r;
  assign crn3_y    = c3y_r;

endmodule

/* hw/rtl/sqvt_box.sv */
`timescale 1ns / 1ps
module sqvt_box (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                crn_valid,
  output logic                                crn_ready,
  input  logic signed [sqvt_pkg::COORD_W-1:0] crn1_x,
  input  logic signed [sqvt_pkg::COORD_W-1:0] crn1_y,
  input  logic signed [sqvt_pkg::COORD_W-1:0] crn2_x,
  input  logic signed [sqvt_pkg::COORD_W-1:0] crn2_y,
  input  logic signed [sqvt_pkg::COORD_W-1:0] crn3_x,
  input  logic signed [sqvt_pkg::COORD_W-1:0] crn3_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sqvt_pkg::sqvt_out_t                 out_data
);

  localparam int unsigned COORD_W  = sqvt_pkg::COORD_W;
  localparam int unsigned EXTENT_W = sqvt_pkg::EXTENT_W;
  localparam int unsigned SAT_W    = sqvt_pkg::SAT_W;

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  assign rdy3      = !v3_r || out_ready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign crn_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= crn_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // stage 1: fourth corner closes the parallelogram
  logic signed [COORD_W-1:0] x1_r [4];
  logic signed [COORD_W-1:0] y1_r [4];

  always_ff @(posedge clk) begin
    if (rdy1) begin
      x1_r[0] <= crn1_x;
      y1_r[0] <= crn1_y;
      x1_r[1] <= crn2_x;
      y1_r[1] <= crn2_y;
      x1_r[2] <= crn3_x;
      y1_r[2] <= crn3_y;
      x1_r[3] <= sqvt_pkg::sat32(SAT_W'(crn1_x) + SAT_W'(crn3_x) - SAT_W'(crn2_x));
      y1_r[3] <= sqvt_pkg::sat32(SAT_W'(crn1_y) + SAT_W'(crn3_y) - SAT_W'(crn2_y));
    end
  end

  // stage 2: two-level min/max tree per axis
  logic signed [COORD_W-1:0] mnx01, mnx23, mxx01, mxx23, mny01, mny23, mxy01, mxy23;
  logic signed [COORD_W-1:0] minx_nxt, maxx_nxt, miny_nxt, maxy_nxt;
  logic signed [COORD_W-1:0] x2_r [4];
  logic signed [COORD_W-1:0] y2_r [4];
  logic signed [COORD_W-1:0] minx_r, maxx_r, miny_r, maxy_r;

  always_comb begin
    mnx01    = (x1_r[1] < x1_r[0]) ? x1_r[1] : x1_r[0];
    mnx23    = (x1_r[3] < x1_r[2]) ? x1_r[3] : x1_r[2];
    mxx01    = (x1_r[1] > x1_r[0]) ? x1_r[1] : x1_r[0];
    mxx23    = (x1_r[3] > x1_r[2]) ? x1_r[3] : x1_r[2];
    mny01    = (y1_r[1] < y1_r[0]) ? y1_r[1] : y1_r[0];
    mny23    = (y1_r[3] < y1_r[2]) ? y1_r[3] : y1_r[2];
    mxy01    = (y1_r[1] > y1_r[0]) ? y1_r[1] : y1_r[0];
    mxy23    = (y1_r[3] > y1_r[2]) ? y1_r[3] : y1_r[2];
    minx_nxt = (mnx23 < mnx01) ? mnx23 : mnx01;
    maxx_nxt = (mxx23 > mxx01) ? mxx23 : mxx01;
    miny_nxt = (mny23 < mny01) ? mny23 : mny01;
    maxy_nxt = (mxy23 > mxy01) ? mxy23 : mxy01;
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      x2_r   <= x1_r;
      y2_r   <= y1_r;
      minx_r <= minx_nxt;
      maxx_r <= maxx_nxt;
      miny_r <= miny_nxt;
      maxy_r <= maxy_nxt;
    end
  end

  // stage 3: extents, clamped to 31 bits
  logic [COORD_W:0]     dx, dy;
  sqvt_pkg::sqvt_out_t  out_nxt;
  sqvt_pkg::sqvt_out_t  out_r;

  always_comb begin
    dx = {maxx_r[COORD_W-1], maxx_r} - {minx_r[COORD_W-1], minx_r};
    dy = {maxy_r[COORD_W-1], maxy_r} - {miny_r[COORD_W-1], miny_r};
    out_nxt.corner1_x  = x2_r[0];
    out_nxt.corner1_y  = y2_r[0];
    out_nxt.corner2_x  = x2_r[1];
    out_nxt.corner2_y  = y2_r[1];
    out_nxt.corner3_x  = x2_r[2];
    out_nxt.corner3_y  = y2_r[2];
    out_nxt.corner4_x  = x2_r[3];
    out_nxt.corner4_y  = y2_r[3];
    out_nxt.box_min_x  = minx_r;
    out_nxt.box_min_y  = miny_r;
    out_nxt.box_width  = (dx[COORD_W:EXTENT_W] != '0) ? '1 : dx[EXTENT_W-1:0];
    out_nxt.box_height = (dy[COORD_W:EXTENT_W] != '0) ? '1 : dy[EXTENT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = out_r;

endmodule

/* hw/rtl/sprite_quad_vertex_transform.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_ready   sqvt_in_t: origin, size, scale, angle, pos
// out_      output     out_valid / out_ready sqvt_out_t: four corners, box min, extents
//
// One item per cycle sustained while out_ready stays high; every item passes
// through the nine register stages: three in the front end (edges, scale
// multiply plus table index, round/clamp plus sin/cos table read), three
// in the rotator (products, sums, translate/clamp), three in the box unit.
// rst_n is synchronous and active low; it clears only the stage valid bits.
// Each stage loads whenever it is empty or the stage after it moves, so a
// stalled out_ready holds finished items in place while bubbles ahead of them
// still fill; in_ready drops only once every stage holds an item.
module sprite_quad_vertex_transform #(
  parameter int unsigned SINE_TABLE_ENTRIES = sqvt_pkg::SINE_TABLE_ENTRIES_DFLT,
  parameter int unsigned FRACTION_BITS      = sqvt_pkg::FRACTION_BITS_DFLT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sqvt_pkg::sqvt_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sqvt_pkg::sqvt_out_t out_data
);

  localparam int unsigned COORD_W = sqvt_pkg::COORD_W;
  localparam int unsigned LOC_W   = sqvt_pkg::LOC_W;

  // front end -> rotator: scaled local rectangle, sin/cos, position
  logic                       loc_valid;
  logic                       loc_ready;
  logic signed [LOC_W-1:0]    loc_x, loc_y, loc_x2, loc_y2;
  logic signed [FRACTION_BITS+1:0] loc_sin, loc_cos;
  logic                       loc_zero;
  logic signed [COORD_W-1:0]  loc_pos_x, loc_pos_y;

  // rotator -> box unit: first three corners in world space
  logic                       crn_valid;
  logic                       crn_ready;
  logic signed [COORD_W-1:0]  crn1_x, crn1_y, crn2_x, crn2_y, crn3_x, crn3_y;

  sqvt_front #(
    .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES),
    .FRACTION_BITS      (FRACTION_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .loc_valid (loc_valid),
    .loc_ready (loc_ready),
    .loc_x     (loc_x),
    .loc_y     (loc_y),
    .loc_x2    (loc_x2),
    .loc_y2    (loc_y2),
    .loc_sin   (loc_sin),
    .loc_cos   (loc_cos),
    .loc_zero  (loc_zero),
    .loc_pos_x (loc_pos_x),
    .loc_pos_y (loc_pos_y)
  );

  // rotate about the pivot, or pass straight through on a zero angle
  sqvt_rotate #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .loc_valid (loc_valid),
    .loc_ready (loc_ready),
    .loc_x     (loc_x),
    .loc_y     (loc_y),
    .loc_x2    (loc_x2),
    .loc_y2    (loc_y2),
    .loc_sin   (loc_sin),
    .loc_cos   (loc_cos),
    .loc_zero  (loc_zero),
    .loc_pos_x (loc_pos_x),
    .loc_pos_y (loc_pos_y),
    .crn_valid (crn_valid),
    .crn_ready (crn_ready),
    .crn1_x    (crn1_x),
    .crn1_y    (crn1_y),
    .crn2_x    (crn2_x),
    .crn2_y    (crn2_y),
    .crn3_x    (crn3_x),
    .crn3_y    (crn3_y)
  );

  // fourth corner, bounding box; its last stage is the output register
  sqvt_box u_box (
    .clk       (clk),
    .rst_n     (rst_n),
    .crn_valid (crn_valid),
    .crn_ready (crn_ready),
    .crn1_x    (crn1_x),
    .crn1_y    (crn1_y),
    .crn2_x    (crn2_x),
    .crn2_y    (crn2_y),
    .crn3_x    (crn3_x),
    .crn3_y    (crn3_y),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;

  // Predictor constants: a full turn is 5760 sixteenths of a degree and the
  // sine table has 1024 entries with 16 fraction bits (the block defaults).
  localparam int TABLE_SIZE = 1024;
  localparam int FRAC = 16;
  localparam int FULL_TURN = 5760;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint LOCAL_MAX = (64'sd1 <<< 35) - 1;
  localparam longint LOCAL_MIN = -(64'sd1 <<< 35);
  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;

  localparam int MIN32 = 32'sh8000_0000;
  localparam int MAX32 = 32'sh7fff_ffff;
  localparam int ONE = 65536;
  localparam int RANDOM_SPRITES = 800;
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  sqvt_pkg::sqvt_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sqvt_pkg::sqvt_out_t out_data;

  sqvt_pkg::sqvt_in_t pending_sprites[$];
  sqvt_pkg::sqvt_out_t expected_quads[$];
  int sprites_total = 0;
  int sprites_sent = 0;
  int rotated_sent = 0;
  int quads_checked = 0;
  int mismatches = 0;
  int stall_cycles = 0;
  logic calm;

  sprite_quad_vertex_transform u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Hold off all random idling on both sides for a stretch of the run so
  // the pipeline is exercised at full rate with back-to-back items.
  assign calm = (sprites_sent >= 300) && (sprites_sent < 450);

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------
  function automatic longint clamp64(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Shift right with round to nearest, ties toward +infinity.
  function automatic longint round_frac(longint v, int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  // Scale one local edge by a Q8.8 factor and clamp to the 36-bit range.
  function automatic longint scale_edge(longint v, longint sc);
    return clamp64(round_frac(v * sc, 8), LOCAL_MIN, LOCAL_MAX);
  endfunction

  // Sine of a Q30 radian angle in [0, 2*pi): fold into the first quadrant,
  // evaluate the odd series to x^13 by Horner steps, round to FRAC bits.
  function automatic longint table_sine(longint unsigned ang);
    longint unsigned r;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned div;
    bit flip;
    int k;
    r = ang;
    flip = 1'b0;
    if (r >= PI_Q30) begin
      flip = 1'b1;
      r = r - PI_Q30;
    end
    if (r > HALF_PI_Q30) begin
      r = PI_Q30 - r;
    end
    x2 = (r * r) >> 30;
    t = ONE_Q30;
    for (k = 6; k >= 1; k--) begin
      div = (2 * k) * (2 * k + 1);
      t = ONE_Q30 - ((x2 * t) >> 30) / div;
    end
    s = (r * t) >> 30;
    s = (s + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
    return flip ? -longint'(s) : longint'(s);
  endfunction

  function automatic sqvt_pkg::sqvt_out_t predict_quad(sqvt_pkg::sqvt_in_t s);
    longint ox, oy, w, h, scx, scy, px, py;
    longint lx, ly, lx2, ly2, sn, cs;
    longint minx, maxx, miny, maxy, ext_x, ext_y;
    longint cx[4];
    longint cy[4];
    longint unsigned a, idx, r, rc;
    sqvt_pkg::sqvt_out_t q;
    int i;
    ox = s.origin_x;
    oy = s.origin_y;
    w = s.size_w;
    h = s.size_h;
    scx = s.scale_x;
    scy = s.scale_y;
    px = s.pos_x;
    py = s.pos_y;
    a = longint'(s.angle) % FULL_TURN;
    lx = scale_edge(-ox, scx);
    ly = scale_edge(-oy, scy);
    lx2 = scale_edge(w - ox, scx);
    ly2 = scale_edge(h - oy, scy);
    if (a == 0) begin
      // no rotation: plain axis-aligned rectangle, translated
      cx[0] = lx + px;  cy[0] = ly + py;
      cx[1] = lx + px;  cy[1] = ly2 + py;
      cx[2] = lx2 + px; cy[2] = ly2 + py;
      cx[3] = lx2 + px; cy[3] = ly + py;
      for (i = 0; i < 4; i++) begin
        cx[i] = clamp64(cx[i], S32_LO, S32_HI);
        cy[i] = clamp64(cy[i], S32_LO, S32_HI);
      end
    end else begin
      idx = (a * TABLE_SIZE) / FULL_TURN;
      r = (idx * TWO_PI_Q30) / TABLE_SIZE;
      rc = r + HALF_PI_Q30;
      if (rc >= TWO_PI_Q30) begin
        rc = rc - TWO_PI_Q30;
      end
      sn = table_sine(r);
      cs = table_sine(rc);
      cx[0] = clamp64(round_frac(lx * cs - ly * sn, FRAC) + px, S32_LO, S32_HI);
      cy[0] = clamp64(round_frac(ly * cs + lx * sn, FRAC) + py, S32_LO, S32_HI);
      cx[1] = clamp64(round_frac(lx * cs - ly2 * sn, FRAC) + px, S32_LO, S32_HI);
      cy[1] = clamp64(round_frac(ly2 * cs + lx * sn, FRAC) + py, S32_LO, S32_HI);
      cx[2] = clamp64(round_frac(lx2 * cs - ly2 * sn, FRAC) + px, S32_LO, S32_HI);
      cy[2] = clamp64(round_frac(ly2 * cs + lx2 * sn, FRAC) + py, S32_LO, S32_HI);
      // fourth corner closes the parallelogram from the clamped corners
      cx[3] = clamp64(cx[0] + cx[2] - cx[1], S32_LO, S32_HI);
      cy[3] = clamp64(cy[0] + cy[2] - cy[1], S32_LO, S32_HI);
    end
    minx = cx[0];
    maxx = cx[0];
    miny = cy[0];
    maxy = cy[0];
    for (i = 1; i < 4; i++) begin
      if (cx[i] < minx) minx = cx[i];
      if (cx[i] > maxx) maxx = cx[i];
      if (cy[i] < miny) miny = cy[i];
      if (cy[i] > maxy) maxy = cy[i];
    end
    ext_x = clamp64(maxx - minx, 0, S32_HI);
    ext_y = clamp64(maxy - miny, 0, S32_HI);
    q.corner1_x = cx[0][31:0];
    q.corner1_y = cy[0][31:0];
    q.corner2_x = cx[1][31:0];
    q.corner2_y = cy[1][31:0];
    q.corner3_x = cx[2][31:0];
    q.corner3_y = cy[2][31:0];
    q.corner4_x = cx[3][31:0];
    q.corner4_y = cy[3][31:0];
    q.box_min_x = minx[31:0];
    q.box_min_y = miny[31:0];
    q.box_width = ext_x[30:0];
    q.box_height = ext_y[30:0];
    return q;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------
  function automatic sqvt_pkg::sqvt_in_t make_sprite(int ox, int oy, int w, int h,
                                                     shortint sx, shortint sy, int ang,
                                                     int px, int py);
    sqvt_pkg::sqvt_in_t s;
    s.origin_x = ox;
    s.origin_y = oy;
    s.size_w = w;
    s.size_h = h;
    s.scale_x = sx;
    s.scale_y = sy;
    s.angle = ang[sqvt_pkg::ANGLE_W-1:0];
    s.pos_x = px;
    s.pos_y = py;
    return s;
  endfunction

  // Signed Q16.16 value with a random integer part in [-span, span].
  function automatic int rand_coord(int span);
    return (int'($urandom_range(0, 2 * span)) - span) * ONE + int'($urandom_range(0, ONE - 1));
  endfunction

  function automatic int pick_extreme();
    int v;
    case ($urandom_range(0, 4))
      0: v = MIN32;
      1: v = MAX32;
      2: v = 0;
      3: v = -1;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic sqvt_pkg::sqvt_in_t random_sprite();
    sqvt_pkg::sqvt_in_t s;
    int kind;
    int ang;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      // typical sprite: modest sizes, scale within [-4, 4], any angle
      ang = ($urandom_range(0, 7) == 0) ? FULL_TURN * $urandom_range(0, 1)
                                        : $urandom_range(0, 8191);
      s = make_sprite(rand_coord(300), rand_coord(300),
                      int'($urandom_range(0, 600)) * ONE + int'($urandom_range(0, ONE - 1)),
                      int'($urandom_range(0, 600)) * ONE + int'($urandom_range(0, ONE - 1)),
                      shortint'(int'($urandom_range(0, 2048)) - 1024),
                      shortint'(int'($urandom_range(0, 2048)) - 1024),
                      ang, rand_coord(20000), rand_coord(20000));
    end else if (kind < 90) begin
      // raw bits everywhere
      s = make_sprite($urandom, $urandom, $urandom, $urandom,
                      shortint'($urandom), shortint'($urandom),
                      $urandom_range(0, 8191), $urandom, $urandom);
    end else begin
      // field extremes mixed together to hit every clamp
      s = make_sprite(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                      shortint'(pick_extreme() >>> 16), shortint'(pick_extreme()),
                      $urandom_range(0, 8191), pick_extreme(), pick_extreme());
    end
    return s;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: present pending items, hold each until accepted
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_quads.push_back(predict_quad(in_data));
        sprites_sent++;
        if ((in_data.angle % FULL_TURN) != 0) rotated_sent++;
      end
      // advance only when the slot is free; otherwise hold valid and payload
      if (!in_valid || in_ready) begin
        if (pending_sprites.size() != 0 && (calm || $urandom_range(0, 99) >= 30)) begin
          in_data <= pending_sprites.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: check each accepted quad against the oldest prediction
  // ---------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, longint got, longint want);
    if (got != want) begin
      report_mismatch($sformatf("quad %0d %s: got %0d expected %0d",
                                quads_checked, name, got, want));
    end
  endtask

  always @(posedge clk) begin
    sqvt_pkg::sqvt_out_t want;
    out_ready <= calm || ($urandom_range(0, 99) >= 30);
    if (rst_n && out_valid && out_ready) begin
      if (expected_quads.size() == 0) begin
        report_mismatch("unexpected quad with nothing outstanding");
      end else begin
        want = expected_quads.pop_front();
        compare_field("corner1_x", out_data.corner1_x, want.corner1_x);
        compare_field("corner1_y", out_data.corner1_y, want.corner1_y);
        compare_field("corner2_x", out_data.corner2_x, want.corner2_x);
        compare_field("corner2_y", out_data.corner2_y, want.corner2_y);
        compare_field("corner3_x", out_data.corner3_x, want.corner3_x);
        compare_field("corner3_y", out_data.corner3_y, want.corner3_y);
        compare_field("corner4_x", out_data.corner4_x, want.corner4_x);
        compare_field("corner4_y", out_data.corner4_y, want.corner4_y);
        compare_field("box_min_x", out_data.box_min_x, want.box_min_x);
        compare_field("box_min_y", out_data.box_min_y, want.box_min_y);
        compare_field("box_width", out_data.box_width, want.box_width);
        compare_field("box_height", out_data.box_height, want.box_height);
        quads_checked++;
      end
    end
    // watchdog: drop the run when no item moves on either side for too long
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence: directed corners of the behavior, then random sprites
  // ---------------------------------------------------------------------
  initial begin
    int n;
    // identity and the cardinal rotations around a centered pivot
    pending_sprites.push_back(make_sprite(0, 0, 16 * ONE, 16 * ONE, 256, 256, 0, 0, 0));
    pending_sprites.push_back(make_sprite(8 * ONE, 8 * ONE, 16 * ONE, 16 * ONE, 256, 256, 1440,
                                          100 * ONE, 50 * ONE));
    pending_sprites.push_back(make_sprite(8 * ONE, 8 * ONE, 16 * ONE, 16 * ONE, 256, 256, 2880,
                                          100 * ONE, 50 * ONE));
    pending_sprites.push_back(make_sprite(8 * ONE, 8 * ONE, 16 * ONE, 16 * ONE, 256, 256, 4320,
                                          100 * ONE, 50 * ONE));
    // smallest nonzero angle and the last angle before a full turn
    pending_sprites.push_back(make_sprite(3 * ONE, 5 * ONE, 40 * ONE, 20 * ONE, 256, 256, 1,
                                          -7 * ONE, 9 * ONE));
    pending_sprites.push_back(make_sprite(3 * ONE, 5 * ONE, 40 * ONE, 20 * ONE, 256, 256, 5759,
                                          -7 * ONE, 9 * ONE));
    // angles past a full turn wrap; an exact turn takes the unrotated path
    pending_sprites.push_back(make_sprite(3 * ONE, 5 * ONE, 40 * ONE, 20 * ONE, 256, 256, 5760,
                                          -7 * ONE, 9 * ONE));
    pending_sprites.push_back(make_sprite(3 * ONE, 5 * ONE, 40 * ONE, 20 * ONE, 256, 256, 8191,
                                          -7 * ONE, 9 * ONE));
    // half scale on odd values lands exactly on rounding ties
    pending_sprites.push_back(make_sprite(-1, 1, 3, -3, 128, 128, 0, 0, 0));
    pending_sprites.push_back(make_sprite(-1, 1, 3, -3, 128, 128, 720, 1, -1));
    // zero scale collapses the quad to the pivot
    pending_sprites.push_back(make_sprite(5 * ONE, 5 * ONE, 10 * ONE, 10 * ONE, 0, 0, 960,
                                          ONE, ONE));
    // scale extremes, mirrored and stretched
    pending_sprites.push_back(make_sprite(2 * ONE, -3 * ONE, 11 * ONE, 7 * ONE, -32768, -32768,
                                          960, 0, 0));
    pending_sprites.push_back(make_sprite(MIN32, MIN32, MAX32, MAX32, 32767, 32767, 0,
                                          MAX32, MAX32));
    pending_sprites.push_back(make_sprite(MIN32, MIN32, MAX32, MAX32, 32767, 32767, 2000,
                                          MAX32, MAX32));
    pending_sprites.push_back(make_sprite(MAX32, MAX32, MIN32, MIN32, -32768, -32768, 0,
                                          MIN32, MIN32));
    // negative size flips the rectangle
    pending_sprites.push_back(make_sprite(0, 0, -20 * ONE, -10 * ONE, 256, 256, 0,
                                          30 * ONE, 30 * ONE));
    pending_sprites.push_back('0);
    pending_sprites.push_back('1);
    // huge rotated quad near the top of the range: corners and the fourth clamp
    pending_sprites.push_back(make_sprite(0, 0, MAX32, MAX32, 256, 256, 2880, MAX32, MAX32));
    // one axis mirrored
    pending_sprites.push_back(make_sprite(4 * ONE, 6 * ONE, 8 * ONE, 12 * ONE, 256, -256, 480,
                                          -50 * ONE, 25 * ONE));
    for (n = 0; n < RANDOM_SPRITES; n++) begin
      pending_sprites.push_back(random_sprite());
    end
    sprites_total = pending_sprites.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // drain: every item in, every quad out, then a little pipeline slack
    while (sprites_sent < sprites_total) @(posedge clk);
    while (expected_quads.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sprites sent: %0d (%0d rotated, %0d unrotated), quads checked: %0d",
             sprites_sent, rotated_sent, sprites_sent - rotated_sent, quads_checked);
    $display("field mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/sqvt_pkg.sv
hw/rtl/sqvt_sine_rom.sv
hw/rtl/sqvt_front.sv
hw/rtl/sqvt_rotate.sv
hw/rtl/sqvt_box.sv
hw/rtl/sprite_quad_vertex_transform.sv
tb/testbench.sv
